FILE: hw/rtl/cmf_pkg.sv
// Package for the cone magnitude filter: widths, constants, codes, types
// and the CORDIC arctangent table. Depends on nothing.
package cmf_pkg;

  localparam int unsigned TrigIterations = 24;
  localparam int unsigned IdxW   = 5;   // index into the 32-entry atan table
  localparam int unsigned AngW   = 31;  // signed half-angle, 2^-21 degree
  localparam int unsigned XyW    = 34;  // CORDIC x and y, Q30
  localparam int unsigned HavW   = 34;  // Q30 products after rounding
  localparam int unsigned ProdW  = 2 * HavW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic signed [AngW-1:0] QuarterTurn = 31'sd188743680;
  localparam logic signed [AngW-1:0] HalfTurn    = 31'sd377487360;
  localparam logic signed [XyW-1:0]  CordicStart = 34'sd652032874;
  localparam logic [ProdW-1:0]       Q30Half     = ProdW'(64'd536870912);
  localparam logic [27:0]            WideRadius  = 28'd188743680;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegCenterRa   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCenterDec  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegConeRadius = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMagLow     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMagHigh    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMagWinOn   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMaxMatches = 3'd6;

  // Datapath operation codes: five CORDIC passes, then two products.
  localparam logic [2:0] OpTh = 3'd0;  // hav(radius/2)
  localparam logic [2:0] OpDd = 3'd1;  // hav(dDec/2)
  localparam logic [2:0] OpDr = 3'd2;  // hav(dRA/2)
  localparam logic [2:0] OpC1 = 3'd3;  // cos(center dec)
  localparam logic [2:0] OpC2 = 3'd4;  // cos(star dec)
  localparam logic [2:0] OpCp = 3'd5;  // cos product
  localparam logic [2:0] OpT  = 3'd6;  // cos product times hav(dRA/2)

  typedef struct packed {
    logic [28:0]        center_ra;
    logic signed [27:0] center_dec;
    logic [27:0]        cone_radius;
    logic signed [15:0] mag_low;
    logic signed [15:0] mag_high;
    logic               mag_window_on;
    logic [19:0]        max_matches;
  } cmf_cfg_t;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       step;
    logic       mul;
    logic       store;
    logic       finish;
    logic [2:0] op;
  } cmf_cmd_t;

  typedef struct packed {
    logic cordic_last;
    logic out_blocked;
  } cmf_sts_t;

  // Doubled round(atan(2^-i) degrees * 2^20).
  function automatic logic signed [AngW-1:0] atan_step(input logic [IdxW-1:0] idx);
    logic [27:0] v;
    case (idx)
      5'd0:  v = 28'd47185920;
      5'd1:  v = 28'd27855475;
      5'd2:  v = 28'd14718068;
      5'd3:  v = 28'd7471121;
      5'd4:  v = 28'd3750058;
      5'd5:  v = 28'd1876857;
      5'd6:  v = 28'd938658;
      5'd7:  v = 28'd469357;
      5'd8:  v = 28'd234682;
      5'd9:  v = 28'd117342;
      5'd10: v = 28'd58671;
      5'd11: v = 28'd29335;
      5'd12: v = 28'd14668;
      5'd13: v = 28'd7334;
      5'd14: v = 28'd3667;
      5'd15: v = 28'd1833;
      5'd16: v = 28'd917;
      5'd17: v = 28'd458;
      5'd18: v = 28'd229;
      5'd19: v = 28'd115;
      5'd20: v = 28'd57;
      5'd21: v = 28'd29;
      5'd22: v = 28'd14;
      5'd23: v = 28'd7;
      5'd24: v = 28'd4;
      5'd25: v = 28'd2;
      5'd26: v = 28'd1;
      default: v = 28'd0;
    endcase
    return signed'({2'b00, v, 1'b0});
  endfunction

endpackage

FILE: hw/rtl/cmf_intf.sv
// Channel interfaces of the cone magnitude filter: configuration writes,
// star records and results. Depends on nothing.
interface cmf_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface cmf_star_if;
  logic               valid;
  logic               ready;
  logic [63:0]        star_id;
  logic [28:0]        star_ra;
  logic signed [27:0] star_dec;
  logic signed [15:0] star_gmag;
  logic               first_of_scan;
  modport source (output valid, output star_id, output star_ra, output star_dec,
                  output star_gmag, output first_of_scan, input ready);
  modport sink (input valid, input star_id, input star_ra, input star_dec,
                input star_gmag, input first_of_scan, output ready);
endinterface

interface cmf_res_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [63:0] out_id;
  logic [31:0] match_total;
  logic        limit_hit;
  modport source (output valid, output matched, output out_id, output match_total,
                  output limit_hit, input ready);
  modport sink (input valid, input matched, input out_id, input match_total,
                input limit_hit, output ready);
endinterface

FILE: hw/rtl/cmf_ctrl.sv
// Sequencer of the cone magnitude filter: steps the datapath through the
// CORDIC passes and products of one item. Depends on cmf_pkg.
module cmf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmf_pkg::cmf_sts_t sts_i,
  output cmf_pkg::cmf_cmd_t cmd_o
);
  import cmf_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StIter  = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StStore = 3'd4;
  localparam logic [2:0] StFin   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d    = OpTh;
          state_d = StStart;
        end
      end
      StStart: begin
        cmd_o.start = 1'b1;
        state_d = StIter;
      end
      StIter: begin
        cmd_o.step = 1'b1;
        if (sts_i.cordic_last) state_d = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d = StStore;
      end
      StStore: begin
        cmd_o.store = 1'b1;
        if (op_q == OpT) begin
          state_d = StFin;
        end else begin
          op_d = op_q + 3'd1;
          state_d = (op_q < OpC2) ? StStart : StMul;
        end
      end
      StFin: begin
        if (!sts_i.out_blocked) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= OpTh;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

FILE: hw/rtl/cmf_datapath.sv
// Datapath of the cone magnitude filter: record latch, shared CORDIC unit,
// shared multiplier, match counter and result register. Depends on cmf_pkg.
module cmf_datapath #(
  parameter int unsigned TRIG_ITERATIONS = cmf_pkg::TrigIterations
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmf_pkg::cmf_cfg_t  cfg_i,
  input  cmf_pkg::cmf_cmd_t  cmd_i,
  output cmf_pkg::cmf_sts_t  sts_o,
  input  logic [63:0]        star_id_i,
  input  logic [28:0]        star_ra_i,
  input  logic signed [27:0] star_dec_i,
  input  logic signed [15:0] star_gmag_i,
  input  logic               first_of_scan_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               matched_o,
  output logic [63:0]        out_id_o,
  output logic [31:0]        match_total_o,
  output logic               limit_hit_o
);
  import cmf_pkg::*;

  localparam int unsigned IterW = $clog2(TRIG_ITERATIONS);
  localparam logic [IterW-1:0] IterLast = IterW'(TRIG_ITERATIONS - 1);

  // Latched record and per-scan state.
  logic [63:0]        id_q;
  logic [28:0]        ra_q;
  logic signed [27:0] dec_q;
  logic               pass_q;
  logic [31:0]        cnt_q;
  logic               stop_q;

  // CORDIC state.
  logic signed [XyW-1:0]  x_q, y_q;
  logic signed [AngW-1:0] z_q;
  logic [IterW-1:0]       iter_q;
  logic                   flip_q, zero_q;

  // Products and intermediate results.
  logic [ProdW-1:0] prod_q;
  logic [HavW-1:0]  th_q, sdd_q, sra_q, c1_q, c2_q, cp_q, t_q;
  logic             n1_q, n2_q;
  logic             out_valid_q;

  // Angle selection and folding into +/-90 degrees.
  logic signed [AngW-1:0] ang, fang;
  logic                   fflip;
  always_comb begin
    case (cmd_i.op)
      OpTh:    ang = signed'({3'b000, cfg_i.cone_radius});
      OpDd:    ang = AngW'(dec_q) - AngW'(cfg_i.center_dec);
      OpDr:    ang = signed'({2'b00, ra_q}) - signed'({2'b00, cfg_i.center_ra});
      OpC1:    ang = AngW'(cfg_i.center_dec) <<< 1;
      default: ang = AngW'(dec_q) <<< 1;
    endcase
    if (ang > QuarterTurn) begin
      fang = ang - HalfTurn;
      fflip = 1'b1;
    end else if (ang < -QuarterTurn) begin
      fang = ang + HalfTurn;
      fflip = 1'b1;
    end else begin
      fang = ang;
      fflip = 1'b0;
    end
  end

  logic signed [XyW-1:0]  dx, dy;
  logic signed [AngW-1:0] zstep;
  logic [HavW-1:0]        s_mag, x_mag, mul_a, mul_b, rnd;
  logic [ProdW-1:0]       prod_rnd;
  assign dx    = y_q >>> iter_q;
  assign dy    = x_q >>> iter_q;
  assign zstep = atan_step(IdxW'(iter_q));
  assign s_mag = y_q[XyW-1] ? HavW'(-y_q) : HavW'(y_q);
  assign x_mag = x_q[XyW-1] ? HavW'(-x_q) : HavW'(x_q);
  assign prod_rnd = prod_q + Q30Half;
  assign rnd = prod_rnd[30 +: HavW];

  always_comb begin
    case (cmd_i.op)
      OpCp:    begin mul_a = c1_q;  mul_b = c2_q;  end
      OpT:     begin mul_a = cp_q;  mul_b = sra_q; end
      default: begin mul_a = s_mag; mul_b = s_mag; end
    endcase
  end

  assign sts_o.cordic_last = (iter_q == IterLast);
  assign sts_o.out_blocked = out_valid_q && !out_ready_i;

  // Scan bookkeeping at the start of an item.
  logic [31:0] cnt_base;
  logic        stop_base, win_ok;
  assign cnt_base  = first_of_scan_i ? 32'd0 : cnt_q;
  assign stop_base = (first_of_scan_i ? 1'b0 : stop_q) ||
                     (cfg_i.max_matches != 20'd0 && cnt_base >= {12'd0, cfg_i.max_matches});
  assign win_ok    = !cfg_i.mag_window_on ||
                     (star_gmag_i >= cfg_i.mag_low && star_gmag_i <= cfg_i.mag_high);

  // Final decision.
  logic [HavW:0] a_val;
  logic          in_cone, hit, stop_new;
  logic [31:0]   cnt_new;
  always_comb begin
    if (n1_q != n2_q) a_val = (sdd_q > t_q) ? {1'b0, sdd_q - t_q} : '0;
    else              a_val = {1'b0, sdd_q} + {1'b0, t_q};
    in_cone  = (cfg_i.cone_radius >= WideRadius) || (a_val <= {1'b0, th_q});
    hit      = pass_q && !stop_q && in_cone;
    cnt_new  = (hit && cnt_q != 32'hFFFF_FFFF) ? cnt_q + 32'd1 : cnt_q;
    stop_new = stop_q || (hit && cfg_i.max_matches != 20'd0 &&
                          cnt_new >= {12'd0, cfg_i.max_matches});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= star_id_i;
      ra_q   <= star_ra_i;
      dec_q  <= star_dec_i;
      pass_q <= win_ok;
    end
    if (cmd_i.start) begin
      x_q    <= CordicStart;
      y_q    <= '0;
      z_q    <= fang;
      iter_q <= '0;
      flip_q <= fflip;
      zero_q <= (fang == '0);
    end else if (cmd_i.step) begin
      if (!z_q[AngW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - zstep;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + zstep;
      end
      iter_q <= iter_q + IterW'(1);
    end
    if (cmd_i.mul) prod_q <= mul_a * mul_b;
    if (cmd_i.store) begin
      case (cmd_i.op)
        OpTh: th_q  <= zero_q ? '0 : rnd;
        OpDd: sdd_q <= zero_q ? '0 : rnd;
        OpDr: sra_q <= zero_q ? '0 : rnd;
        OpC1: begin c1_q <= x_mag; n1_q <= flip_q ^ x_q[XyW-1]; end
        OpC2: begin c2_q <= x_mag; n2_q <= flip_q ^ x_q[XyW-1]; end
        OpCp: cp_q  <= rnd;
        default: t_q <= rnd;
      endcase
    end
    if (cmd_i.finish) begin
      matched_o     <= hit;
      out_id_o      <= id_q;
      match_total_o <= cnt_new;
      limit_hit_o   <= stop_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q  <= cnt_base;
        stop_q <= stop_base;
      end else if (cmd_i.finish) begin
        cnt_q  <= cnt_new;
        stop_q <= stop_new;
      end
      if (cmd_i.finish)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/cone_magnitude_filter_unit.sv
// Top level of the cone magnitude filter: configuration registers and the
// controller and datapath. Depends on cmf_pkg, cmf_intf, cmf_ctrl, cmf_datapath.
//
// Star records arrive on star_i, one item per valid/ready handshake, and each
// produces exactly one result item on result_o: the matched flag, the record
// id, the running match count of the scan and the limit flag. Registers are
// written on cfg_i, which is always ready; write them only while no item is
// in flight. Unknown indexes are ignored.
// Each item runs in turn through the single shared CORDIC unit, which runs
// five passes of TRIG_ITERATIONS steps each, and through the one shared
// multiplier used for the squares and the two cosine products; a new item
// is not taken while one is in flight. The block is ready for the next item
// in the cycle after the result is registered, even if the receiver has not
// yet taken it.
// If the receiver stalls, the result stays in its output register and the
// block waits at the end of the following item until the register frees.
// Reset clears the match count, the stop flag, the sequencer and the output
// valid, and loads the register reset values (magnitude window -4096..32767).
module cone_magnitude_filter_unit #(
  parameter int unsigned TRIG_ITERATIONS = cmf_pkg::TrigIterations
) (
  input  logic clk_i,
  input  logic rst_ni,
  cmf_cfg_if.sink   cfg_i,
  cmf_star_if.sink  star_i,
  cmf_res_if.source result_o
);
  import cmf_pkg::*;

  cmf_cfg_t cfg_q;
  cmf_cmd_t cmd;
  cmf_sts_t sts;

  assign cfg_i.ready = 1'b1;

  // Register writes mask the data to each field's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_ra     <= '0;
      cfg_q.center_dec    <= '0;
      cfg_q.cone_radius   <= '0;
      cfg_q.mag_low       <= -16'sd4096;
      cfg_q.mag_high      <= 16'sd32767;
      cfg_q.mag_window_on <= 1'b0;
      cfg_q.max_matches   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegCenterRa:   cfg_q.center_ra     <= cfg_i.data[28:0];
        RegCenterDec:  cfg_q.center_dec    <= signed'(cfg_i.data[27:0]);
        RegConeRadius: cfg_q.cone_radius   <= cfg_i.data[27:0];
        RegMagLow:     cfg_q.mag_low       <= signed'(cfg_i.data[15:0]);
        RegMagHigh:    cfg_q.mag_high      <= signed'(cfg_i.data[15:0]);
        RegMagWinOn:   cfg_q.mag_window_on <= cfg_i.data[0];
        RegMaxMatches: cfg_q.max_matches   <= cfg_i.data[19:0];
        default: ;
      endcase
    end
  end

  cmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (star_i.valid),
    .in_ready_o (star_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cmf_datapath #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .star_id_i       (star_i.star_id),
    .star_ra_i       (star_i.star_ra),
    .star_dec_i      (star_i.star_dec),
    .star_gmag_i     (star_i.star_gmag),
    .first_of_scan_i (star_i.first_of_scan),
    .out_valid_o     (result_o.valid),
    .out_ready_i     (result_o.ready),
    .matched_o       (result_o.matched),
    .out_id_o        (result_o.out_id),
    .match_total_o   (result_o.match_total),
    .limit_hit_o     (result_o.limit_hit)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking bench for the cone magnitude filter: drives star records and
// register writes, predicts every result item and compares it field by field.
// Depends on cmf_pkg, the channel interfaces and cone_magnitude_filter_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cmf_pkg::*;

  localparam longint HalfTurnL  = 377487360;
  localparam longint QuarterL   = 188743680;
  localparam longint StartL     = 652032874;
  localparam longint RaMax      = 377487359;
  localparam longint DecMax     = 94371840;
  localparam longint OneDegree  = 1048576;
  localparam int     HoldCycles  = 600;
  localparam int     LimitCycles = 1500000;
  localparam int     DrainCycles = 5 * TrigIterations + 40;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  // Arctangent steps in 2^-20 degree; the rotation doubles them.
  localparam longint AtanTab[32] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic [63:0]        id;
    logic [28:0]        ra;
    logic signed [27:0] dec;
    logic signed [15:0] gmag;
    logic               first;
  } star_t;

  typedef struct {
    logic        matched;
    logic [63:0] id;
    logic [31:0] total;
    logic        limit;
  } filter_res_t;

  // Keeps a copy of the registers and scan state and the queue of results
  // still owed by the block.
  class match_scoreboard;
    cmf_cfg_t    cfg;
    logic [31:0] match_count;
    bit          stopped;
    filter_res_t owed_results[$];
    int          errors;

    function new();
      cfg.center_ra     = '0;
      cfg.center_dec    = '0;
      cfg.cone_radius   = '0;
      cfg.mag_low       = -16'sd4096;
      cfg.mag_high      = 16'sd32767;
      cfg.mag_window_on = 1'b0;
      cfg.max_matches   = '0;
      match_count = '0;
      stopped     = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] d);
      case (idx)
        RegCenterRa:   cfg.center_ra     = d[28:0];
        RegCenterDec:  cfg.center_dec    = d[27:0];
        RegConeRadius: cfg.cone_radius   = d[27:0];
        RegMagLow:     cfg.mag_low       = d[15:0];
        RegMagHigh:    cfg.mag_high      = d[15:0];
        RegMagWinOn:   cfg.mag_window_on = d[0];
        RegMaxMatches: cfg.max_matches   = d[19:0];
        default: ;
      endcase
    endfunction

    // Brings an angle into +/-90 degrees; each half turn flips the cosine.
    function longint fold(longint h, inout bit flip);
      while (h > QuarterL) begin
        h -= HalfTurnL;
        flip = !flip;
      end
      while (h < -QuarterL) begin
        h += HalfTurnL;
        flip = !flip;
      end
      return h;
    endfunction

    function void rotate(longint z, output longint c, output longint s);
      longint x, y, dx, dy, st;
      x = StartL;
      y = 0;
      for (int i = 0; i < TrigIterations && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        st = AtanTab[i] * 2;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= st;
        end else begin
          x += dx;
          y -= dy;
          z += st;
        end
      end
      c = x;
      s = y;
    endfunction

    function longint unsigned hav(longint h);
      bit flip;
      longint c, s;
      longint unsigned m;
      flip = 1'b0;
      h = fold(h, flip);
      if (h == 0) return 0;
      rotate(h, c, s);
      m = (s < 0) ? -s : s;
      return (m * m + 64'd536870912) >> 30;
    endfunction

    function longint unsigned cos_abs(longint z, output bit neg);
      bit flip;
      longint c, s;
      flip = 1'b0;
      z = fold(z, flip);
      rotate(z, c, s);
      neg = flip != (c < 0);
      return (c < 0) ? -c : c;
    endfunction

    function bit in_cone(longint ra, longint dec);
      longint rad, cdec;
      longint unsigned th, sdd, sra, c1, c2, cp, t, a;
      bit n1, n2;
      rad  = longint'(cfg.cone_radius);
      cdec = longint'(cfg.center_dec);
      if (rad >= QuarterL) return 1'b1;
      th  = hav(rad);
      sdd = hav(dec - cdec);
      sra = hav(ra - longint'(cfg.center_ra));
      c1  = cos_abs(cdec * 2, n1);
      c2  = cos_abs(dec * 2, n2);
      cp  = (c1 * c2 + 64'd536870912) >> 30;
      t   = (cp * sra + 64'd536870912) >> 30;
      if (n1 != n2) a = (sdd > t) ? sdd - t : 0;
      else a = sdd + t;
      return a <= th;
    endfunction

    function void check_limit();
      if (cfg.max_matches != 0 && match_count >= 32'(cfg.max_matches)) stopped = 1'b1;
    endfunction

    // Predicts the result of an accepted record and queues it.
    function void note_star(star_t s);
      filter_res_t r;
      bit pass;
      if (s.first) begin
        match_count = '0;
        stopped     = 1'b0;
      end
      check_limit();
      pass = !(cfg.mag_window_on && (s.gmag < cfg.mag_low || s.gmag > cfg.mag_high));
      r.matched = 1'b0;
      if (pass && !stopped && in_cone(longint'(s.ra), longint'(s.dec))) begin
        r.matched = 1'b1;
        if (match_count != '1) match_count++;
        check_limit();
      end
      r.id    = s.id;
      r.total = match_count;
      r.limit = stopped;
      owed_results = {owed_results, r};
    endfunction

    function void check_result(filter_res_t got);
      filter_res_t want;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item, id %h", got.id);
        return;
      end
      want = owed_results.pop_front();
      if (got.matched !== want.matched || got.id !== want.id ||
          got.total !== want.total || got.limit !== want.limit) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected m=%0b id=%h n=%0d lim=%0b, got m=%0b id=%h n=%0d lim=%0b",
                   want.matched, want.id, want.total, want.limit,
                   got.matched, got.id, got.total, got.limit);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  cmf_cfg_if  cfg_bus ();
  cmf_star_if star_bus ();
  cmf_res_if  res_bus ();

  match_scoreboard sb;
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  cone_magnitude_filter_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .star_i   (star_bus),
    .result_o (res_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Inputs start at known values; reset is asserted at the start, once.
  initial begin
    rst_ni                 <= 1'b0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.index          <= '0;
    cfg_bus.data           <= '0;
    star_bus.valid         <= 1'b0;
    star_bus.star_id       <= '0;
    star_bus.star_ra       <= '0;
    star_bus.star_dec      <= '0;
    star_bus.star_gmag     <= '0;
    star_bus.first_of_scan <= 1'b0;
    res_bus.ready          <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run-away guard: ends the run if it takes far longer than a correct one.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LimitCycles) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result receiver. It draws a random wait per item while idle_on is set, and
  // when asked it holds ready low for a long stretch so that the block backs
  // up and stalls its input channel.
  initial begin
    int gap;
    filter_res_t got;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        res_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (res_bus.valid !== 1'b1);
      got.matched = res_bus.matched;
      got.id      = res_bus.out_id;
      got.total   = res_bus.match_total;
      got.limit   = res_bus.limit_hit;
      sb.check_result(got);
    end
  end

  // Leaves cfg valid high across a batch of writes; the caller lowers it.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    sb.write_reg(idx, d);
  endtask

  task automatic program_regs(cmf_cfg_t c, bit poke_unused);
    write_reg(RegCenterRa, 32'(c.center_ra));
    write_reg(RegCenterDec, 32'(c.center_dec));
    write_reg(RegConeRadius, 32'(c.cone_radius));
    write_reg(RegMagLow, 32'(c.mag_low));
    write_reg(RegMagHigh, 32'(c.mag_high));
    write_reg(RegMagWinOn, 32'(c.mag_window_on));
    write_reg(RegMaxMatches, 32'(c.max_matches));
    // A write to an index with no register must change nothing.
    if (poke_unused) write_reg(RegUnused, $urandom);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Keeps valid high into the next item when its drawn wait is zero.
  task automatic send_star(star_t s);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      star_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    star_bus.valid         <= 1'b1;
    star_bus.star_id       <= s.id;
    star_bus.star_ra       <= s.ra;
    star_bus.star_dec      <= s.dec;
    star_bus.star_gmag     <= s.gmag;
    star_bus.first_of_scan <= s.first;
    do @(posedge clk_i); while (star_bus.ready !== 1'b1);
    sb.note_star(s);
  endtask

  // Sender pause: nothing more is offered until every result has come back.
  task automatic wait_idle();
    star_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.owed_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic star_t mk_star(logic [63:0] id, longint ra, longint dec, longint g, bit f);
    star_t s;
    s.id    = id;
    s.ra    = ra[28:0];
    s.dec   = dec[27:0];
    s.gmag  = g[15:0];
    s.first = f;
    return s;
  endfunction

  // Most records land near the cone so that matches and the limit are
  // exercised; the rest are spread over the whole sky.
  function automatic star_t rand_star();
    longint span, ra, dec, g, lo, hi;
    span = longint'(sb.cfg.cone_radius) * 2 + OneDegree;
    if (span > (longint'(1) << 29)) span = longint'(1) << 29;
    if ($urandom_range(0, 9) < 7) begin
      ra  = longint'(sb.cfg.center_ra) + longint'($urandom_range(0, 32'(2 * span))) - span;
      dec = longint'(sb.cfg.center_dec) + longint'($urandom_range(0, 32'(2 * span))) - span;
      while (ra < 0) ra += HalfTurnL;
      while (ra > RaMax) ra -= HalfTurnL;
      if (dec > DecMax) dec = DecMax;
      if (dec < -DecMax) dec = -DecMax;
    end else begin
      ra  = longint'($urandom_range(0, 32'(RaMax)));
      dec = longint'($urandom_range(0, 32'(2 * DecMax))) - DecMax;
    end
    if (sb.cfg.mag_window_on && $urandom_range(0, 1)) begin
      lo = longint'(sb.cfg.mag_low) - 200;
      hi = longint'(sb.cfg.mag_high) + 200;
      if (lo < -4096) lo = -4096;
      if (hi > 32767) hi = 32767;
      if (hi < lo) hi = lo;
      g = lo + longint'($urandom_range(0, 32'(hi - lo)));
    end else begin
      g = longint'($urandom_range(0, 36863)) - 4096;
    end
    return mk_star({$urandom, $urandom}, ra, dec, g, $urandom_range(0, 39) == 0);
  endfunction

  function automatic cmf_cfg_t rand_cfg();
    cmf_cfg_t c;
    longint lo, hi;
    c.center_ra  = 29'($urandom_range(0, 32'(RaMax)));
    c.center_dec = 28'(longint'($urandom_range(0, 32'(2 * DecMax))) - DecMax);
    case ($urandom_range(0, 7))
      0:       c.cone_radius = 28'($urandom_range(0, 32'(QuarterL)));
      1:       c.cone_radius = 28'($urandom_range(0, 32'(OneDegree / 16)));
      default: c.cone_radius = 28'($urandom_range(0, 32'(4 * OneDegree)));
    endcase
    lo = longint'($urandom_range(0, 36863)) - 4096;
    hi = longint'($urandom_range(0, 36863)) - 4096;
    // An inverted window now and then; otherwise an ordered one.
    if (lo > hi && $urandom_range(0, 3) != 0) begin
      c.mag_low  = hi[15:0];
      c.mag_high = lo[15:0];
    end else begin
      c.mag_low  = lo[15:0];
      c.mag_high = hi[15:0];
    end
    c.mag_window_on = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0:       c.max_matches = '0;
      1:       c.max_matches = 20'hFFFFF;
      2:       c.max_matches = 20'($urandom);
      default: c.max_matches = 20'($urandom_range(1, 8));
    endcase
    return c;
  endfunction

  initial begin
    cmf_cfg_t c;
    sb = new();
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Reset registers: a zero cone at the origin, window off.
    send_star(mk_star(64'd0, 0, 0, 0, 1'b1));
    send_star(mk_star('1, RaMax, DecMax, 32767, 1'b0));
    send_star(mk_star(64'h8000_0000_0000_0000, 0, -DecMax, -4096, 1'b0));
    // Half a turn in RA gives a half angle of exactly 90 degrees.
    send_star(mk_star(64'h5555_aaaa_5555_aaaa, QuarterL, 0, 1024, 1'b0));
    send_star(mk_star(64'h0123_4567_89ab_cdef, 1, 0, 0, 1'b0));
    wait_idle();

    // Cone at the far RA edge and the north limit, window and limit of two.
    c.center_ra     = RaMax[28:0];
    c.center_dec    = DecMax[27:0];
    c.cone_radius   = 28'(5 * OneDegree);
    c.mag_low       = 16'sd0;
    c.mag_high      = 16'sd10240;
    c.mag_window_on = 1'b1;
    c.max_matches   = 20'd2;
    program_regs(c, 1'b0);
    send_star(mk_star(64'd11, RaMax, DecMax, 0, 1'b1));
    send_star(mk_star(64'd12, RaMax, DecMax, 10240, 1'b0));
    send_star(mk_star(64'd13, RaMax, DecMax, 5000, 1'b0));
    send_star(mk_star(64'd14, RaMax, DecMax, 5000, 1'b1));
    send_star(mk_star(64'd15, RaMax, DecMax, -1, 1'b0));
    send_star(mk_star(64'd16, RaMax, DecMax, 10241, 1'b0));
    send_star(mk_star(64'd17, RaMax, -DecMax, 100, 1'b0));
    send_star(mk_star(64'd18, 0, DecMax - OneDegree, 100, 1'b0));
    wait_idle();

    // Wide cone with an inverted window: nothing passes until the window is off.
    c.center_ra     = '0;
    c.center_dec    = 28'(-DecMax);
    c.cone_radius   = QuarterL[27:0];
    c.mag_low       = 16'sd100;
    c.mag_high      = -16'sd100;
    c.mag_window_on = 1'b1;
    c.max_matches   = 20'hFFFFF;
    program_regs(c, 1'b1);
    send_star(mk_star(64'd21, 12345, 0, 0, 1'b1));
    send_star(mk_star(64'd22, RaMax, DecMax, -4096, 1'b0));
    wait_idle();
    write_reg(RegMagWinOn, 32'd0);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
    send_star(mk_star(64'd23, RaMax, DecMax, 32767, 1'b0));
    send_star(mk_star(64'd24, 0, -DecMax, -4096, 1'b0));
    wait_idle();

    // Random phases, each under fresh settings.
    for (int ph = 0; ph < 9; ph++) begin
      program_regs(rand_cfg(), ph == 3);
      idle_on  = !(ph == 2 || ph == 6);
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < 180; n++) send_star(rand_star());
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    sb.errors += sb.owed_results.size();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cmf_pkg.sv
hw/rtl/cmf_intf.sv
hw/rtl/cmf_ctrl.sv
hw/rtl/cmf_datapath.sv
hw/rtl/cone_magnitude_filter_unit.sv
tb/testbench.sv
